>>> sv/sabp_pkg.sv
// ----------------------------------------------------------------------------
// sabp_pkg : shared types and helpers for the straight-alpha blend unit
// Item layout, config struct, register index codes and the divide-by-255.
// ----------------------------------------------------------------------------
`default_nettype none

package sabp_pkg;

    localparam int unsigned PIXEL_W     = 32;
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLOBAL_ALPHA     = 8'd0,
        CFG_SOURCE_HAS_ALPHA = 8'd1,
        CFG_DEST_HAS_ALPHA   = 8'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [CHAN_W-1:0] global_alpha;
        logic              source_has_alpha;
        logic              dest_has_alpha;
    } t_cfg;

    // What the back end has to do with an item
    typedef enum logic [1:0] {
        KIND_ZERO  = 2'd0,  // keep destination, no write
        KIND_FULL  = 2'd1,  // copy source word
        KIND_BLEND = 2'd2   // per-channel mix
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAN_W-1:0]  alpha;
        logic [PIXEL_W-1:0] src;
        logic [PIXEL_W-1:0] dst;
    } t_item;

    // Exact floor(x/255) for x up to 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

>>> sv/straight_alpha_blend_pixel_unit.sv
// ----------------------------------------------------------------------------
// straight_alpha_blend_pixel_unit : ARGB8888 straight-alpha 'over' blender
// Front end resolves alpha and classifies, a short queue decouples it from
// the two-stage back end that mixes channels and holds the output register.
// ----------------------------------------------------------------------------
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_source_pixel,     | into block
//          | i_dest_pixel                                |
//  out     | o_out_valid, i_out_stall, o_blended_pixel,  | out of block
//          | o_write_enable                              |
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index,      | into block
//          | i_cfg_data                                  |
//
//  One item per clock sustained while i_out_stall stays low. When the queue
//  is empty, an accepted item is written into the queue, then loaded into
//  the sum stage, then into the output stage, which drives o_out_valid.
//  Synchronous active-low reset empties queue and pipeline and loads the
//  registers with global_alpha 255, source alpha on, destination alpha off.
//  o_in_stall rises only when the queue is full; the queue absorbs up to
//  P_QUEUE_DEPTH items while the output is stalled. Config writes are always taken (ready tied).
// ----------------------------------------------------------------------------
`default_nettype none

module straight_alpha_blend_pixel_unit #(
    parameter int unsigned P_QUEUE_DEPTH = sabp_pkg::QUEUE_DEPTH
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // input items
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [sabp_pkg::PIXEL_W-1:0]     i_source_pixel,
    input  wire [sabp_pkg::PIXEL_W-1:0]     i_dest_pixel,
    // result items
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [sabp_pkg::PIXEL_W-1:0]    o_blended_pixel,
    output logic                            o_write_enable,
    // configuration writes
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [sabp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [sabp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // register file
    sabp_pkg::t_cfg  r_cfg, n_cfg;

    // front to queue, queue to back
    sabp_pkg::t_item front_item, head_item;
    logic            push, pop, q_full, q_nonempty;

    assign o_cfg_ready = 1'b1;

    // Unknown indexes fall through and leave the registers alone
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sabp_pkg::CFG_GLOBAL_ALPHA:     n_cfg.global_alpha     = i_cfg_data;
                sabp_pkg::CFG_SOURCE_HAS_ALPHA: n_cfg.source_has_alpha = i_cfg_data[0];
                sabp_pkg::CFG_DEST_HAS_ALPHA:   n_cfg.dest_has_alpha   = i_cfg_data[0];
                default:                        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.global_alpha     <= sabp_pkg::ALPHA_FULL;
            r_cfg.source_has_alpha <= 1'b1;
            r_cfg.dest_has_alpha   <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front: alpha resolve and classification, straight into the queue
    sabp_front u_front (
        .i_cfg          (r_cfg),
        .i_valid        (i_in_valid),
        .i_source_pixel (i_source_pixel),
        .i_dest_pixel   (i_dest_pixel),
        .i_full         (q_full),
        .o_push         (push),
        .o_item         (front_item)
    );

    // Stall comes from the registered queue count only
    assign o_in_stall = q_full;

    sabp_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (front_item),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_item     (head_item)
    );

    // Back: weighted sums, divide by 255, output register
    sabp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dest_has_alpha (r_cfg.dest_has_alpha),
        .i_nonempty       (q_nonempty),
        .i_item           (head_item),
        .o_pop            (pop),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_blended_pixel  (o_blended_pixel),
        .o_write_enable   (o_write_enable)
    );

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push == (i_in_valid && !o_in_stall))
        else $error("queue push out of step with input accept");

endmodule

`default_nettype wire

>>> sv/sabp_front.sv
// ----------------------------------------------------------------------------
// sabp_front : alpha resolve and item classification
// Forms the effective alpha and tags each item for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sabp_front (
    input  wire sabp_pkg::t_cfg                     i_cfg,
    input  wire                                     i_valid,
    input  wire [sabp_pkg::PIXEL_W-1:0]             i_source_pixel,
    input  wire [sabp_pkg::PIXEL_W-1:0]             i_dest_pixel,
    input  wire                                     i_full,
    output logic                                    o_push,
    output sabp_pkg::t_item                         o_item
);

    logic [sabp_pkg::CHAN_W-1:0] src_a;
    logic [15:0]                 scaled;
    logic [sabp_pkg::CHAN_W-1:0] eff_a;

    always_comb begin
        src_a  = i_cfg.source_has_alpha ? i_source_pixel[31:24] : sabp_pkg::ALPHA_FULL;
        scaled = 16'(src_a) * 16'(i_cfg.global_alpha);
        if (i_cfg.global_alpha != sabp_pkg::ALPHA_FULL) begin
            eff_a = sabp_pkg::div255(scaled);
        end else begin
            eff_a = src_a;
        end
    end

    always_comb begin
        o_item.alpha = eff_a;
        o_item.src   = i_source_pixel;
        o_item.dst   = i_dest_pixel;
        if (eff_a == '0) begin
            o_item.kind = sabp_pkg::KIND_ZERO;
        end else if (eff_a == sabp_pkg::ALPHA_FULL) begin
            o_item.kind = sabp_pkg::KIND_FULL;
        end else begin
            o_item.kind = sabp_pkg::KIND_BLEND;
        end
    end

    assign o_push = i_valid && !i_full;

endmodule

`default_nettype wire

>>> sv/sabp_queue.sv
// ----------------------------------------------------------------------------
// sabp_queue : short item queue between front and back end
// Register-based FIFO, full flag taken from a registered count.
// ----------------------------------------------------------------------------
`default_nettype none

module sabp_queue #(
    parameter int unsigned DEPTH = sabp_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire sabp_pkg::t_item i_item,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_nonempty,
    output sabp_pkg::t_item  o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sabp_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full     = (r_count == FULL_CNT);
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_nonempty))
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> sv/sabp_back.sv
// ----------------------------------------------------------------------------
// sabp_back : two-stage blend pipeline with output register
// Stage 1 forms the weighted sums, stage 2 divides by 255 and packs.
// ----------------------------------------------------------------------------
`default_nettype none

module sabp_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_dest_has_alpha,
    input  wire                          i_nonempty,
    input  wire sabp_pkg::t_item         i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [sabp_pkg::PIXEL_W-1:0] o_blended_pixel,
    output logic                         o_write_enable
);

    localparam int unsigned NCH = 3;

    logic en1, en2;

    // stage 1
    logic                         r_v1;
    sabp_pkg::t_kind              r_kind1;
    logic [sabp_pkg::PIXEL_W-1:0] r_src1, r_dst1;
    logic [sabp_pkg::CHAN_W-1:0]  r_alpha1;
    logic [15:0]                  r_sum1 [NCH];
    logic [15:0]                  r_asum1;
    logic [15:0]                  n_sum1 [NCH];
    logic [15:0]                  n_asum1;
    logic [sabp_pkg::CHAN_W-1:0]  inv_a;

    // stage 2 / output register
    logic                         r_v2;
    logic [sabp_pkg::PIXEL_W-1:0] r_pixel2, n_pixel2;
    logic                         r_we2, n_we2;

    assign en2   = !r_v2 || !i_stall;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_nonempty && en1;

    always_comb begin
        logic [16:0] acc;
        inv_a = sabp_pkg::ALPHA_FULL - i_item.alpha;
        for (int c = 0; c < NCH; c++) begin
            acc = 17'(16'(i_item.src[c*8 +: 8]) * 16'(i_item.alpha))
                + 17'(16'(i_item.dst[c*8 +: 8]) * 16'(inv_a));
            n_sum1[c] = acc[15:0];
        end
        n_asum1 = 16'(i_item.dst[31:24]) * 16'(inv_a);
    end

    always_comb begin
        logic [sabp_pkg::CHAN_W-1:0] na;
        na       = r_alpha1 + sabp_pkg::div255(r_asum1);
        n_pixel2 = r_src1;
        n_we2    = 1'b1;
        unique case (r_kind1)
            sabp_pkg::KIND_ZERO: begin
                n_pixel2 = r_dst1;
                n_we2    = 1'b0;
            end
            sabp_pkg::KIND_FULL: begin
                n_pixel2 = r_src1;
            end
            sabp_pkg::KIND_BLEND: begin
                for (int c = 0; c < NCH; c++) begin
                    n_pixel2[c*8 +: 8] = sabp_pkg::div255(r_sum1[c]);
                end
                n_pixel2[31:24] = i_dest_has_alpha ? na : 8'h00;
            end
            default: begin
                n_pixel2 = r_src1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= o_pop;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind1  <= i_item.kind;
            r_src1   <= i_item.src;
            r_dst1   <= i_item.dst;
            r_alpha1 <= i_item.alpha;
            r_sum1   <= n_sum1;
            r_asum1  <= n_asum1;
        end
        if (en2 && r_v1) begin
            r_pixel2 <= n_pixel2;
            r_we2    <= n_we2;
        end
    end

    assign o_valid         = r_v2;
    assign o_blended_pixel = r_pixel2;
    assign o_write_enable  = r_we2;

    a_stage1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !en1) |=> r_v1)
        else $error("stage 1 item lost under stall");
    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_v1 || !r_v2 || !i_stall))
        else $error("pop while pipeline blocked");

endmodule

`default_nettype wire
